@@ src/sle_pkg.sv @@
package sle_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOCATE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_RES  = 2'd2
    } t_state;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;

    // broadcast to every cell of the row
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ src/sle_cell.sv @@
module sle_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  sle_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                 i_pos0,
    input  logic [CW-1:0]                 i_count,
    input  logic [sle_pkg::VALUE_W-1:0]   i_prev_data,
    input  logic [sle_pkg::VALUE_W-1:0]   i_next_data,
    output logic [sle_pkg::VALUE_W-1:0]   o_data,
    output logic                          o_match
);
    import sle_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos0) begin
                n_data = i_prev_data;
            end else if (MY_IDX == i_pos0) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos0) begin
                n_data = i_next_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (MY_IDX < i_count) && (r_data == i_ctl.value);

endmodule

@@ src/sle_find.sv @@
// First-match search: halves a registered (hit, index) row once per step.
module sle_find #(
    parameter int DEPTH = 64,
    localparam int LVL  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int P    = 1 << LVL
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [DEPTH-1:0] i_match,
    output logic             o_hit,
    output logic [LVL-1:0]   o_idx
);
    import sle_pkg::*;

    logic [P-1:0]   r_hit;
    logic [LVL-1:0] r_idx [P];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < P; i++) begin
                r_hit[i] <= (i < DEPTH) ? i_match[i] : 1'b0;
                r_idx[i] <= LVL'(i);
            end
        end else if (i_step) begin
            for (int i = 0; i < P / 2; i++) begin
                r_hit[i] <= r_hit[2*i] | r_hit[2*i+1];
                r_idx[i] <= r_hit[2*i] ? r_idx[2*i] : r_idx[2*i+1];
            end
        end
    end

    assign o_hit = r_hit[0];
    assign o_idx = r_idx[0];

endmodule

@@ src/sequential_list_engine.sv @@
// channel | direction | handshake               | fields
// input   | in        | i_in_valid / o_in_stall  | i_func, i_position, i_value
// result  | out       | o_out_valid / i_out_stall| o_status, o_found_position, o_length
//
// Insert and delete update the cell row at the input transfer; clear only resets
// the length. Locate waits for the halving search over the row's match bits; no
// new item is taken until the current result has been staged for output.
// Synchronous active-low reset empties the list; entries need no clearing.
// A result waits in the output register while the next item is taken;
// a stalled output only holds back the item after that.
module sequential_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [sle_pkg::POS_W-1:0]          i_position,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic [sle_pkg::POS_W-1:0]          o_found_position,
    output logic [sle_pkg::POS_W-1:0]          o_length
);
    import sle_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LVL = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW  = $clog2(LVL + 1);
    localparam int XW  = (CW > POS_W) ? CW : POS_W;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_step;
    logic          r_locate;

    logic [1:0]       r_res_status;
    logic [POS_W-1:0] r_res_len;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [POS_W-1:0] r_out_found;
    logic [POS_W-1:0] r_out_len;

    logic accept, load_out, do_step;
    t_func func;

    logic [XW-1:0] pos_x, cnt_x;
    logic          full, ins_ok, del_ok;
    logic [CW-1:0] pos0;
    t_cell_ctl     ctl;
    logic [1:0]    acc_status;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   match;
    logic               f_hit;
    logic [LVL-1:0]     f_idx;
    logic [XW-1:0]      f_pos;
    logic [1:0]         res_status;
    logic [POS_W-1:0]   res_found;

    assign func  = t_func'(i_func);
    assign pos_x = XW'(i_position);
    assign cnt_x = XW'(r_count);
    assign full  = cnt_x >= XW'(DEPTH);
    assign ins_ok = !full && (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
    assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign pos0   = CW'(pos_x - XW'(1));

    assign ctl.ins   = accept && (func == FN_INSERT) && ins_ok;
    assign ctl.del   = accept && (func == FN_DELETE) && del_ok;
    assign ctl.value = i_value;

    // FSM outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        do_step    = (r_state == S_SCAN);
        load_out   = (r_state == S_RES) && (!r_out_valid || !i_out_stall);
    end
    assign accept = i_in_valid && !o_in_stall;

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (func == FN_LOCATE) ? S_SCAN : S_RES;
                end
            end
            S_SCAN: begin
                if (r_step == LW'(1)) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        acc_status = ST_OK;
        case (func)
            FN_INSERT: begin
                if (full) begin
                    acc_status = ST_FULL;
                end else if (!ins_ok) begin
                    acc_status = ST_BADPOS;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            FN_DELETE: begin
                if (!del_ok) begin
                    acc_status = ST_BADPOS;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            FN_CLEAR: n_count = '0;
            default:  acc_status = ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
                r_step  <= LW'(LVL);
            end else if (do_step) begin
                r_step <= r_step - LW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // locate result is read from the search unit once it has settled
    assign f_pos      = XW'(f_idx) + XW'(1);
    assign res_status = !r_locate ? r_res_status : (f_hit ? ST_OK : ST_NOTFOUND);
    assign res_found  = (r_locate && f_hit) ? f_pos[POS_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_locate     <= (func == FN_LOCATE);
            r_res_status <= acc_status;
            r_res_len    <= POS_W'(XW'(n_count));
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_found  <= res_found;
            r_out_len    <= r_res_len;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [VALUE_W-1:0] prev_d, next_d;
            if (k == 0) begin : g_first
                assign prev_d = ctl.value;
            end else begin : g_prev
                assign prev_d = cell_data[k-1];
            end
            if (k == DEPTH - 1) begin : g_last
                assign next_d = cell_data[k];
            end else begin : g_next
                assign next_d = cell_data[k+1];
            end
            sle_cell #(
                .DEPTH (DEPTH),
                .IDX   (k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_pos0      (pos0),
                .i_count     (r_count),
                .i_prev_data (prev_d),
                .i_next_data (next_d),
                .o_data      (cell_data[k]),
                .o_match     (match[k])
            );
        end
    endgenerate

    sle_find #(
        .DEPTH (DEPTH)
    ) u_find (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_step  (do_step),
        .i_match (match),
        .o_hit   (f_hit),
        .o_idx   (f_idx)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_length         = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(DEPTH))
        else $error("list length beyond depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (func == FN_CLEAR) |=> r_count == '0)
        else $error("clear left entries");

    a_full_insert_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (func == FN_INSERT) && full |=> $stable(r_count))
        else $error("insert into full list changed length");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second item taken before result was staged");

endmodule

@@ tb/sequential_list_engine_tb.sv @@
module sequential_list_engine_tb;

    import sle_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int IDLE_PCT   = 38;
    localparam int DRAIN_WAIT = 20;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   found;
        logic [POS_W-1:0]   length;
    } t_result;

    typedef struct {
        t_func                      func;
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  value;
        bit                         typed;
        t_result                    res;
    } t_row;

    localparam t_result NO_RES = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_func = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic [POS_W-1:0]           o_found_position;
    logic [POS_W-1:0]           o_length;

    // shadow copy of the list
    logic signed [VALUE_W-1:0]  list_mem [0:LIST_DEPTH-1];
    int                         list_len = 0;

    t_result                    pending_q [$];
    t_result                    head_res;
    t_row                       dir_tab [$];
    int                         mismatch_cnt = 0;
    bit                         idle_on = 1'b1;

    sequential_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // applies one operation to the shadow list and returns its result
    task automatic apply_list_op(input t_func f, input logic [POS_W-1:0] p,
                                 input logic signed [VALUE_W-1:0] v, output t_result r);
        int pi;
        int k;
        pi = int'(p);
        r.status = ST_OK;
        r.found  = '0;
        case (f)
            FN_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (pi < 1 || pi > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = list_len; k >= pi; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pi-1] = v;
                    list_len++;
                end
            end
            FN_DELETE: begin
                if (pi < 1 || pi > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = pi; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end
            end
            FN_LOCATE: begin
                r.status = ST_NOTFOUND;
                for (k = 0; k < list_len; k++) begin
                    if (r.status == ST_NOTFOUND && list_mem[k] == v) begin
                        r.status = ST_OK;
                        r.found  = POS_W'(k + 1);
                    end
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        r.length = POS_W'(list_len);
    endtask

    task automatic send_item(input t_func f, input logic [POS_W-1:0] p,
                             input logic signed [VALUE_W-1:0] v,
                             input bit typed, input t_result typed_res);
        t_result r;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_position <= p;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_op(f, p, v, r);
        pending_q.push_back(typed ? typed_res : r);
    endtask

    // sender holds off until every pending result has arrived
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input t_func f, input int p, input logic signed [VALUE_W-1:0] v,
                           input bit typed, input t_status st, input int fnd, input int len);
        t_row row;
        row.func       = f;
        row.pos        = POS_W'(p);
        row.value      = v;
        row.typed      = typed;
        row.res.status = st;
        row.res.found  = POS_W'(fnd);
        row.res.length = POS_W'(len);
        dir_tab.push_back(row);
    endtask

    task automatic send_random(input int ins_pct, input int del_pct, input int loc_pct);
        int                         sel;
        t_func                      f;
        logic [POS_W-1:0]           p;
        logic signed [VALUE_W-1:0]  v;
        sel = $urandom_range(99);
        if (sel < ins_pct)
            f = FN_INSERT;
        else if (sel < ins_pct + del_pct)
            f = FN_DELETE;
        else if (sel < ins_pct + del_pct + loc_pct)
            f = FN_LOCATE;
        else
            f = FN_CLEAR;
        p = POS_W'($urandom_range(127, 0));
        if ($urandom_range(99) < 85) begin
            if (f == FN_INSERT)
                p = POS_W'($urandom_range(list_len + 1, 1));
            else if (list_len > 0)
                p = POS_W'($urandom_range(list_len, 1));
        end
        // small values give duplicates for locate
        if ($urandom_range(99) < 30)
            v = int'($urandom_range(6, 0)) - 3;
        else
            v = $urandom;
        if (f == FN_LOCATE && list_len > 0 && $urandom_range(99) < 65)
            v = list_mem[$urandom_range(list_len - 1, 0)];
        send_item(f, p, v, 1'b0, NO_RES);
    endtask

    task automatic run_phase(input int n, input bit idling,
                             input int ins_pct, input int del_pct, input int loc_pct);
        idle_on = idling;
        repeat (n) send_random(ins_pct, del_pct, loc_pct);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("result transfer with nothing pending", 0, 0);
            end else begin
                head_res = pending_q.pop_front();
                if (o_status !== head_res.status)
                    report_mismatch("status", int'(o_status), int'(head_res.status));
                if (o_found_position !== head_res.found)
                    report_mismatch("found_position", int'(o_found_position),
                                    int'(head_res.found));
                if (o_length !== head_res.length)
                    report_mismatch("length", int'(o_length), int'(head_res.length));
            end
        end
    end

    initial begin
        // func pos value typed status found length
        add_row(FN_LOCATE, 0,   32'sd0,           1, ST_NOTFOUND, 0, 0);
        add_row(FN_DELETE, 1,   32'sd0,           1, ST_BADPOS,   0, 0);
        add_row(FN_INSERT, 0,   32'sd5,           1, ST_BADPOS,   0, 0);
        add_row(FN_INSERT, 2,   32'sd5,           1, ST_BADPOS,   0, 0);
        add_row(FN_INSERT, 1,   32'sh8000_0000,   1, ST_OK,       0, 1);
        add_row(FN_INSERT, 2,   32'sh7FFF_FFFF,   1, ST_OK,       0, 2);
        add_row(FN_INSERT, 1,   32'sd0,           1, ST_OK,       0, 3);
        add_row(FN_INSERT, 127, -32'sd1,          1, ST_BADPOS,   0, 3);
        add_row(FN_LOCATE, 0,   32'sh7FFF_FFFF,   1, ST_OK,       3, 3);
        add_row(FN_LOCATE, 127, 32'sh8000_0000,   1, ST_OK,       2, 3);
        add_row(FN_LOCATE, 0,   -32'sd1,          1, ST_NOTFOUND, 0, 3);
        add_row(FN_INSERT, 4,   -32'sd1,          1, ST_OK,       0, 4);
        add_row(FN_INSERT, 2,   32'sd0,           1, ST_OK,       0, 5);
        add_row(FN_LOCATE, 0,   32'sd0,           1, ST_OK,       1, 5);
        add_row(FN_DELETE, 6,   32'sd0,           1, ST_BADPOS,   0, 5);
        add_row(FN_DELETE, 0,   32'sd0,           1, ST_BADPOS,   0, 5);
        add_row(FN_DELETE, 1,   -32'sd1,          1, ST_OK,       0, 4);
        add_row(FN_LOCATE, 3,   -32'sd1,          0, ST_OK,       0, 0);
        add_row(FN_DELETE, 4,   32'sd0,           1, ST_OK,       0, 3);
        add_row(FN_LOCATE, 0,   32'sh8000_0000,   0, ST_OK,       0, 0);
        add_row(FN_CLEAR,  127, -32'sd1,          1, ST_OK,       0, 0);
        add_row(FN_CLEAR,  0,   32'sd0,           1, ST_OK,       0, 0);
        add_row(FN_LOCATE, 0,   32'sh7FFF_FFFF,   1, ST_NOTFOUND, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n])
            send_item(dir_tab[n].func, dir_tab[n].pos, dir_tab[n].value,
                      dir_tab[n].typed, dir_tab[n].res);

        // fill to the top, then the full-list cases: full wins over a bad position
        repeat (LIST_DEPTH)
            send_item(FN_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom,
                      1'b0, NO_RES);
        send_item(FN_INSERT, 127, 32'sd1, 1'b0, NO_RES);
        send_item(FN_INSERT, 0,   32'sd1, 1'b0, NO_RES);
        send_item(FN_INSERT, 65,  32'sd1, 1'b0, NO_RES);
        send_item(FN_LOCATE, 0, list_mem[LIST_DEPTH-1], 1'b0, NO_RES);
        send_item(FN_DELETE, 65, 32'sd0, 1'b0, NO_RES);
        send_item(FN_DELETE, 64, 32'sd0, 1'b0, NO_RES);
        send_item(FN_INSERT, 64, 32'sh7FFF_FFFF, 1'b0, NO_RES);
        send_item(FN_LOCATE, 0, 32'sh7FFF_FFFF, 1'b0, NO_RES);
        send_item(FN_DELETE, 1, 32'sd0, 1'b0, NO_RES);
        send_item(FN_CLEAR, 0, 32'sd0, 1'b0, NO_RES);
        drain_results();

        run_phase(500, 1'b1, 55, 20, 22);
        run_phase(450, 1'b0, 65, 15, 18);
        run_phase(450, 1'b1, 30, 45, 23);
        run_phase(450, 1'b1, 50, 30, 18);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/sle_pkg.sv
src/sle_cell.sv
src/sle_find.sv
src/sequential_list_engine.sv
tb/sequential_list_engine_tb.sv
